### rtl/eedu_pkg.sv
// ----------------------------------------------------------------------------
// Exception entry and event dispatch package
// Request and result types, queue entry, opcodes, kinds, CP0 constants and exception entry.
// ----------------------------------------------------------------------------
`default_nettype none

package eedu_pkg;

    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_TEST   = 2'd1;
    localparam logic [1:0] OP_EXC    = 2'd2;
    localparam logic [1:0] OP_STATUS = 2'd3;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_EXC  = 2'd1;
    localparam logic [1:0] KIND_CNT  = 2'd2;
    localparam logic [1:0] KIND_FIRE = 2'd3;

    localparam logic [31:0] STATUS_RESET = 32'h1090_0000;
    localparam logic [31:0] CAUSE_BD     = 32'h8000_0000;
    localparam logic [31:0] STATUS_BEV   = 32'h0040_0000;
    localparam logic [31:0] VEC_BOOT     = 32'hbfc0_0180;
    localparam logic [31:0] VEC_NORMAL   = 32'h8000_0080;
    localparam logic [31:0] MODE_MASK    = 32'h0000_003f;
    localparam logic [31:0] MODE_PUSH    = 32'h0000_000f;
    localparam logic [31:0] IE_MASK      = 32'h0000_0401;
    localparam logic [31:0] CAUSE_INT    = 32'h0000_0400;
    localparam logic [7:0]  GTE_MASK     = 8'hfe;
    localparam logic [7:0]  GTE_OP       = 8'h4a;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  source;
        logic [31:0] cycle_now;
        logic [31:0] value;
        logic [10:0] irq_status;
        logic [10:0] irq_mask;
        logic [31:0] fetch_word;
        logic        in_delay_slot;
        logic [31:0] current_pc;
        logic [31:0] counter_start;
        logic [31:0] counter_period;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  fired_source;
        logic [31:0] new_pc;
        logic [31:0] epc_out;
        logic [31:0] cause_out;
        logic [31:0] status_out;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  src;
        logic        arm_ok;
        logic [31:0] now;
        logic [31:0] value;
        logic        irq_hit;
        logic        cnt_due;
        logic        slot;
        logic [31:0] pc;
    } qent_t;

    typedef struct packed {
        logic [31:0] cause;
        logic [31:0] epc;
        logic [31:0] status;
        logic [31:0] vec;
    } exc_t;

    function automatic exc_t take_exc(input logic [31:0] status, input logic [31:0] code,
                                      input logic slot, input logic [31:0] pc);
        exc_t r;
        r.cause  = slot ? (code | CAUSE_BD) : code;
        r.epc    = slot ? (pc - 32'd4) : pc;
        r.vec    = ((status & STATUS_BEV) != 32'd0) ? VEC_BOOT : VEC_NORMAL;
        r.status = (status & ~MODE_MASK) | ((status & MODE_PUSH) << 2);
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/eedu_front.sv
// ----------------------------------------------------------------------------
// Exception entry and event dispatch front end
// Accept requests, classify them and push them into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module eedu_front
    import eedu_pkg::*;
#(
    parameter int NUM_SOURCES = 12
)
(
    input  wire logic  req_valid,
    output logic       req_stall,
    input  wire req_t  req_data,
    input  wire logic  q_full,
    output logic       push,
    output qent_t      ent
);

    logic [31:0] src_w;
    logic [31:0] elapsed;
    logic        gte;

    assign req_stall = q_full;
    assign push      = req_valid && !q_full;

    assign src_w   = 32'(req_data.source);
    assign elapsed = req_data.cycle_now - req_data.counter_start;
    assign gte     = (req_data.fetch_word[31:24] & GTE_MASK) == GTE_OP;

    always_comb
    begin
        ent.op      = req_data.opcode;
        ent.src     = req_data.source;
        ent.arm_ok  = src_w < 32'(NUM_SOURCES);
        ent.now     = req_data.cycle_now;
        ent.value   = req_data.value;
        ent.irq_hit = ((req_data.irq_status & req_data.irq_mask) != 11'd0) && !gte;
        ent.cnt_due = elapsed >= req_data.counter_period;
        ent.slot    = req_data.in_delay_slot;
        ent.pc      = req_data.current_pc;
    end

endmodule

`default_nettype wire

### rtl/eedu_queue.sv
// ----------------------------------------------------------------------------
// Exception entry and event dispatch queue
// Short FIFO of classified requests between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module eedu_queue
    import eedu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire qent_t ent,
    input  wire logic  pop,
    output logic       full,
    output logic       q_valid,
    output qent_t      head
);

    qent_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= ent;
        end
    end

endmodule

`default_nettype wire

### rtl/eedu_back.sv
// ----------------------------------------------------------------------------
// Exception entry and event dispatch back end
// Execute queued requests: CP0 registers, event store, scan and results.
// ----------------------------------------------------------------------------
`default_nettype none

module eedu_back
    import eedu_pkg::*;
#(
    parameter int NUM_SOURCES = 12
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    input  wire logic  q_valid,
    input  wire qent_t head,
    output logic       pop,
    output logic       res_valid,
    input  wire logic  res_stall,
    output res_t       res_data
);

    localparam int SW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_CNT  = 5'b00100,
        S_SCAN = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [31:0]            status_reg, status_next;
    logic [31:0]            cause_reg, cause_next;
    logic [31:0]            epc_reg, epc_next;
    logic [NUM_SOURCES-1:0] pending_reg, pending_next;
    logic                   serial_off_reg, serial_off_next;
    logic                   hold_v_reg, hold_v_next;
    res_t                   hold_reg, hold_next;
    logic                   out_v_reg, out_v_next;
    res_t                   out_reg, out_next;
    logic [NUM_SOURCES-1:0] rem_reg, rem_next;
    logic                   cmp_v_reg, cmp_v_next;
    logic [SW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [31:0]            rd_start_reg;
    logic [31:0]            rd_delay_reg;

    logic [31:0]            start_mem [NUM_SOURCES];
    logic [31:0]            delay_mem [NUM_SOURCES];

    logic                   out_free;
    logic                   can_prod;
    logic                   prod;
    res_t                   prod_res;
    logic                   mem_we;
    logic                   rd_en;
    logic [31:0]            src_w;
    logic [SW-1:0]          arm_addr;
    logic [NUM_SOURCES-1:0] elig;
    logic [NUM_SOURCES-1:0] low;
    logic [SW-1:0]          enc;
    logic                   hit;
    logic                   adv;
    logic                   irq_take;
    logic [31:0]            exc_code;
    logic                   exc_slot;
    exc_t                   exc;

    function automatic res_t mk_res(input logic [1:0] kind, input logic [3:0] src,
                                    input logic [31:0] pc, input logic [31:0] epc,
                                    input logic [31:0] cause, input logic [31:0] status);
        res_t r;
        r.kind         = kind;
        r.fired_source = src;
        r.new_pc       = pc;
        r.epc_out      = epc;
        r.cause_out    = cause;
        r.status_out   = status;
        r.last         = 1'b0;
        return r;
    endfunction

    assign res_valid = out_v_reg;
    assign res_data  = out_reg;

    assign out_free = !out_v_reg || !res_stall;
    assign can_prod = !hold_v_reg || out_free;

    assign src_w    = 32'(head.src);
    assign arm_addr = src_w[SW-1:0];
    assign elig     = pending_reg & ~NUM_SOURCES'(serial_off_reg);
    assign low      = rem_reg & (~rem_reg + 1'b1);
    assign hit      = cmp_v_reg && ((head.now - rd_start_reg) >= rd_delay_reg);
    assign adv      = !hit || can_prod;
    assign irq_take = head.irq_hit && ((status_reg & IE_MASK) == IE_MASK);
    assign exc_code = (head.op == OP_EXC) ? head.value : CAUSE_INT;
    assign exc_slot = (head.op == OP_EXC) ? head.slot : 1'b0;
    assign exc      = take_exc(status_reg, exc_code, exc_slot, head.pc);

    always_comb
    begin
        enc = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (low[i])
            begin
                enc = enc | SW'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        cause_next      = cause_reg;
        epc_next        = epc_reg;
        pending_next    = pending_reg;
        serial_off_next = cfg_we ? cfg_wdata : serial_off_reg;
        hold_v_next     = hold_v_reg;
        hold_next       = hold_reg;
        out_v_next      = out_v_reg && res_stall;
        out_next        = out_reg;
        rem_next        = rem_reg;
        cmp_v_next      = cmp_v_reg;
        cmp_idx_next    = cmp_idx_reg;
        prod            = 1'b0;
        prod_res        = mk_res(KIND_ACK, 4'd0, 32'd0, epc_reg, cause_reg, status_reg);
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        pop             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (head.op)
                    OP_ARM:
                    begin
                        if (can_prod)
                        begin
                            prod = 1'b1;
                            if (head.arm_ok)
                            begin
                                mem_we                 = 1'b1;
                                pending_next[arm_addr] = 1'b1;
                            end
                            state_next = S_FIN;
                        end
                    end
                    OP_STATUS:
                    begin
                        if (can_prod)
                        begin
                            prod        = 1'b1;
                            status_next = head.value;
                            prod_res    = mk_res(KIND_ACK, 4'd0, 32'd0, epc_reg, cause_reg,
                                                 head.value);
                            state_next  = S_FIN;
                        end
                    end
                    OP_EXC:
                    begin
                        if (can_prod)
                        begin
                            prod        = 1'b1;
                            status_next = exc.status;
                            cause_next  = exc.cause;
                            epc_next    = exc.epc;
                            prod_res    = mk_res(KIND_EXC, 4'd0, exc.vec, exc.epc, exc.cause,
                                                 exc.status);
                            state_next  = S_FIN;
                        end
                    end
                    default:
                    begin
                        if (!irq_take)
                        begin
                            state_next = S_CNT;
                        end
                        else if (can_prod)
                        begin
                            prod        = 1'b1;
                            status_next = exc.status;
                            cause_next  = exc.cause;
                            epc_next    = exc.epc;
                            prod_res    = mk_res(KIND_EXC, 4'd0, exc.vec, exc.epc, exc.cause,
                                                 exc.status);
                            state_next  = S_CNT;
                        end
                    end
                endcase
            end
            S_CNT:
            begin
                if (!head.cnt_due || can_prod)
                begin
                    prod       = head.cnt_due;
                    prod_res   = mk_res(KIND_CNT, 4'd0, 32'd0, epc_reg, cause_reg,
                                        status_reg);
                    rem_next   = elig;
                    cmp_v_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (adv)
                begin
                    if (hit)
                    begin
                        prod                      = 1'b1;
                        pending_next[cmp_idx_reg] = 1'b0;
                        prod_res = mk_res(KIND_FIRE, 4'(cmp_idx_reg), 32'd0, epc_reg,
                                          cause_reg, status_reg);
                    end
                    rd_en        = rem_reg != '0;
                    cmp_v_next   = rem_reg != '0;
                    cmp_idx_next = enc;
                    rem_next     = rem_reg & ~low;
                    if (rem_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_v_next = 1'b1;
                    if (hold_v_reg)
                    begin
                        out_next = hold_reg;
                    end
                    else
                    begin
                        out_next = mk_res(KIND_ACK, 4'd0, 32'd0, epc_reg, cause_reg,
                                          status_reg);
                    end
                    out_next.last = 1'b1;
                    hold_v_next   = 1'b0;
                    pop           = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hold the newest result back until the next one shows whether it ends the request
        if (prod)
        begin
            if (hold_v_reg)
            begin
                out_v_next = 1'b1;
                out_next   = hold_reg;
            end
            hold_v_next = 1'b1;
            hold_next   = prod_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            status_reg     <= STATUS_RESET;
            cause_reg      <= '0;
            epc_reg        <= '0;
            pending_reg    <= '0;
            serial_off_reg <= 1'b0;
            hold_v_reg     <= 1'b0;
            out_v_reg      <= 1'b0;
            rem_reg        <= '0;
            cmp_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            status_reg     <= status_next;
            cause_reg      <= cause_next;
            epc_reg        <= epc_next;
            pending_reg    <= pending_next;
            serial_off_reg <= serial_off_next;
            hold_v_reg     <= hold_v_next;
            out_v_reg      <= out_v_next;
            rem_reg        <= rem_next;
            cmp_v_reg      <= cmp_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg    <= hold_next;
        out_reg     <= out_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            start_mem[arm_addr] <= head.now;
            delay_mem[arm_addr] <= head.value;
        end
        if (rd_en)
        begin
            rd_start_reg <= start_mem[enc];
            rd_delay_reg <= delay_mem[enc];
        end
    end

endmodule

`default_nettype wire

### rtl/exception_entry_and_event_dispatch_unit.sv
// ----------------------------------------------------------------------------
// Exception entry and event dispatch unit
// CP0 exception entry with a deadline scheduler for the event sources.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  request  | req_valid / req_stall | req_data  (req_t)
//  result   | res_valid / res_stall | res_data  (res_t)
//  config   | cfg_we                | cfg_wdata (serial events off)
//
// Arm, status write, exception: back end states EXEC, FIN; branch test: EXEC,
// CNT, SCAN of pending sources, one event store read per cycle unless stalled,
// then FIN. The two-entry queue lets requests in while the back end works.
// Reset leaves status at its boot value, nothing pending; no clearing pass.
// A stalled result halts the back end only when a second result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module exception_entry_and_event_dispatch_unit
    import eedu_pkg::*;
#(
    parameter int NUM_SOURCES = 12
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res_data
);

    logic  q_full;
    logic  push;
    logic  pop;
    logic  q_valid;
    qent_t ent;
    qent_t head;

    eedu_front #(.NUM_SOURCES(NUM_SOURCES)) u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .q_full    (q_full),
        .push      (push),
        .ent       (ent)
    );

    eedu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .ent     (ent),
        .pop     (pop),
        .full    (q_full),
        .q_valid (q_valid),
        .head    (head)
    );

    eedu_back #(.NUM_SOURCES(NUM_SOURCES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire

### rtl/eedu_checker.sv
// ----------------------------------------------------------------------------
// Exception entry and event dispatch checker
// Port-level checks on the result stream of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module eedu_checker
    import eedu_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic res_valid,
    input wire logic res_stall,
    input wire res_t res_data
);

    logic        res_acc;
    logic        prev_last_reg;
    logic [1:0]  prev_kind_reg;
    logic [3:0]  prev_src_reg;
    logic [31:0] prev_status_reg;
    logic [31:0] prev_epc_reg;

    assign res_acc = res_valid && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_last_reg <= 1'b1;
        end
        else if (res_acc)
        begin
            prev_last_reg <= res_data.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_acc)
        begin
            prev_kind_reg   <= res_data.kind;
            prev_src_reg    <= res_data.fired_source;
            prev_status_reg <= res_data.status_out;
            prev_epc_reg    <= res_data.epc_out;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_res_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && !prev_last_reg |->
            (res_data.kind > prev_kind_reg) ||
            (res_data.kind == KIND_FIRE && prev_kind_reg == KIND_FIRE &&
             res_data.fired_source > prev_src_reg))
        else $error("results of one request out of order");

    a_res_regs: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && !prev_last_reg && res_data.kind != KIND_EXC |->
            res_data.status_out == prev_status_reg && res_data.epc_out == prev_epc_reg)
        else $error("status or EPC changed without an exception");

endmodule

bind exception_entry_and_event_dispatch_unit eedu_checker u_eedu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

`default_nettype wire
